### rtl/assert_macros.svh
// Assertion macros shared by the delta sleep queue RTL.
// Defining NO_ASSERTIONS turns every macro into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dsq_pkg.sv
// Shared types and constants of the delta sleep queue.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dsq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } stat_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  task_id;
        logic [15:0] delay;
    } req_t;

    typedef struct packed {
        stat_t       status;
        logic [7:0]  out_task;
        logic [15:0] out_delta;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_FIX,
        S_NEW,
        S_LINK,
        S_DONE
    } state_t;

    // How a freshly written entry is hooked into the chain.
    typedef enum logic [1:0] {
        LK_NONE,
        LK_TAIL,
        LK_HEAD,
        LK_PREV
    } lk_t;

    // Field write enables of the slot memory.
    typedef struct packed {
        logic tid_en;
        logic delta_en;
        logic next_en;
    } ram_we_t;

    // Slot pool requests.
    typedef struct packed {
        logic take;
        logic give;
    } fm_ctrl_t;

endpackage

### rtl/dsq_slot_ram.sv
// Slot memory of the delta sleep queue: task id, delta and link per slot.
// One write port with field enables, one registered read port. Uses dsq_pkg.
`timescale 1ns / 1ps

module dsq_slot_ram #(
    parameter int DEPTH = dsq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  dsq_pkg::ram_we_t we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [7:0]       wr_tid,
    input  logic [15:0]      wr_delta,
    input  logic [AW-1:0]    wr_next,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [7:0]       rd_tid,
    output logic [15:0]      rd_delta,
    output logic [AW-1:0]    rd_next
);

    logic [7:0]    tid_mem   [DEPTH];
    logic [15:0]   delta_mem [DEPTH];
    logic [AW-1:0] link_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.tid_en)
        begin
            tid_mem[wr_addr] <= wr_tid;
        end
        if (we.delta_en)
        begin
            delta_mem[wr_addr] <= wr_delta;
        end
        if (we.next_en)
        begin
            link_mem[wr_addr] <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tid   <= tid_mem[rd_addr];
            rd_delta <= delta_mem[rd_addr];
            rd_next  <= link_mem[rd_addr];
        end
    end

endmodule

### rtl/dsq_free_map.sv
// Free slot map of the delta sleep queue with a registered lowest-free finder.
// Uses dsq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsq_free_map #(
    parameter int DEPTH = dsq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dsq_pkg::fm_ctrl_t ctrl,
    input  logic [AW-1:0]     rel_idx,
    output logic [AW-1:0]     alloc_idx,
    output logic [DEPTH-1:0]  free_mask
);

    logic [DEPTH-1:0] free_mask_reg;
    logic [DEPTH-1:0] free_mask_next;
    logic [AW-1:0]    low_reg;
    logic [AW-1:0]    low_next;

    always_comb
    begin
        free_mask_next = free_mask_reg;
        if (ctrl.take)
        begin
            free_mask_next[low_reg] = 1'b0;
        end
        if (ctrl.give)
        begin
            free_mask_next[rel_idx] = 1'b1;
        end
    end

    // The lowest free slot is found from the current map and registered, so
    // the index follows a map change in the cycle after it.
    always_comb
    begin
        low_next = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (free_mask_reg[i])
            begin
                low_next = AW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_mask_reg <= '1;
            low_reg       <= '0;
        end
        else
        begin
            free_mask_reg <= free_mask_next;
            low_reg       <= low_next;
        end
    end

    assign alloc_idx = low_reg;
    assign free_mask = free_mask_reg;

    `ASSERT_IMPL(a_take_free, clk, rst_n, ctrl.take, free_mask_reg[low_reg])
    `ASSERT_IMPL(a_give_busy, clk, rst_n, ctrl.give, !free_mask_reg[rel_idx])
    `ASSERT_ALWAYS(a_take_give_excl, clk, rst_n, !(ctrl.take && ctrl.give))

endmodule

### rtl/delta_sleep_queue.sv
// Top level of the delta sleep queue: request sequencer, list pointers and
// result register. Uses dsq_pkg, dsq_slot_ram, dsq_free_map, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block keeps a timer delta list of up to DEPTH entries in a slot memory
// with a registered read. One request is worked on at a time. An append or a
// sorted insert into an empty list writes just the new entry; an append to a
// non-empty list also writes the old tail's link, and a pop reads the head
// entry and then unlinks it. A sorted insert and a remove by id walk the
// chain from the head, one linked entry per cycle through the single memory
// read port. A sorted insert that lands at the head rewrites the old head's
// delta and then writes the new entry; one that lands at the tail writes the
// new entry and then the old tail's link; one that lands behind an existing
// entry rewrites the next entry's delta, writes the new entry and then links
// it from the entry before. A pop or a remove on an empty list and an insert
// into a full table go straight to the result with no memory access. A new
// request is taken while an earlier result still waits on a stalled output;
// the sequencer only holds its own next result until the output register
// frees. Slot contents are not cleared at reset, so the block is ready right
// after reset; new entries take the lowest-numbered free slot.
module delta_sleep_queue #(
    parameter int DEPTH = dsq_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dsq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dsq_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dsq_pkg::state_t state_reg, state_next;
    dsq_pkg::op_t    op_reg, op_next;
    dsq_pkg::lk_t    link_reg, link_next;
    dsq_pkg::rsp_t   res_reg, res_next;
    dsq_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [7:0]      tid_reg, tid_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     fix_reg, fix_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   prev_reg, prev_next;
    logic [AW-1:0]   n_reg, n_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic            have_prev_reg, have_prev_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   count_reg, count_next;

    // Memory and pool interface.
    dsq_pkg::ram_we_t  ram_we;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_tid;
    logic [15:0]       wr_delta;
    logic [AW-1:0]     wr_next;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_tid;
    logic [15:0]       rd_delta;
    logic [AW-1:0]     rd_next;
    dsq_pkg::fm_ctrl_t fm_ctrl;
    logic [AW-1:0]     rel_idx;
    logic [AW-1:0]     alloc_idx;
    logic [DEPTH-1:0]  free_mask;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic [CW-1:0]     k_inc;
    logic              walk_last;
    logic              delta_lt;
    logic              id_match;
    logic              rsp_free;

    // The sequencer never reads the memory in a cycle in which it writes, and
    // every walk starts after the previous request's writes have landed, so no
    // forwarding path is needed.
    dsq_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk      (clk),
        .we       (ram_we),
        .wr_addr  (wr_addr),
        .wr_tid   (wr_tid),
        .wr_delta (wr_delta),
        .wr_next  (wr_next),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_tid   (rd_tid),
        .rd_delta (rd_delta),
        .rd_next  (rd_next)
    );

    dsq_free_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_free (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fm_ctrl),
        .rel_idx   (rel_idx),
        .alloc_idx (alloc_idx),
        .free_mask (free_mask)
    );

    assign req_stall = (state_reg != dsq_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign k_inc     = k_reg + CW'(1);
    assign walk_last = (k_inc == count_reg);
    assign delta_lt  = (rd_delta < rem_reg);
    assign id_match  = (rd_tid == tid_reg);
    // The output register can take a result when it is empty or draining.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.opcode)
                        dsq_pkg::OP_APPEND:
                        begin
                            state_next = is_full ? dsq_pkg::S_DONE : dsq_pkg::S_NEW;
                        end
                        dsq_pkg::OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                state_next = dsq_pkg::S_DONE;
                            end
                            else if (is_empty)
                            begin
                                state_next = dsq_pkg::S_NEW;
                            end
                            else
                            begin
                                state_next = dsq_pkg::S_WALK_RD;
                            end
                        end
                        dsq_pkg::OP_POP:
                        begin
                            state_next = is_empty ? dsq_pkg::S_DONE : dsq_pkg::S_POP_RD;
                        end
                        dsq_pkg::OP_REMOVE:
                        begin
                            state_next = is_empty ? dsq_pkg::S_DONE : dsq_pkg::S_WALK_RD;
                        end
                        default:
                        begin
                            state_next = dsq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            dsq_pkg::S_POP_RD:
            begin
                state_next = dsq_pkg::S_POP_CHK;
            end
            dsq_pkg::S_POP_CHK:
            begin
                state_next = dsq_pkg::S_DONE;
            end
            dsq_pkg::S_WALK_RD:
            begin
                state_next = dsq_pkg::S_WALK_CHK;
            end
            dsq_pkg::S_WALK_CHK:
            begin
                if (op_reg == dsq_pkg::OP_INSERT)
                begin
                    if (!delta_lt)
                    begin
                        state_next = dsq_pkg::S_FIX;
                    end
                    else if (walk_last)
                    begin
                        state_next = dsq_pkg::S_NEW;
                    end
                end
                else if (id_match || walk_last)
                begin
                    state_next = dsq_pkg::S_DONE;
                end
            end
            dsq_pkg::S_FIX:
            begin
                state_next = dsq_pkg::S_NEW;
            end
            dsq_pkg::S_NEW:
            begin
                if (link_reg == dsq_pkg::LK_TAIL || link_reg == dsq_pkg::LK_PREV)
                begin
                    state_next = dsq_pkg::S_LINK;
                end
                else
                begin
                    state_next = dsq_pkg::S_DONE;
                end
            end
            dsq_pkg::S_LINK:
            begin
                state_next = dsq_pkg::S_DONE;
            end
            dsq_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = dsq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dsq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory and pool controls.
    always_comb
    begin
        op_next        = op_reg;
        link_next      = link_reg;
        res_next       = res_reg;
        tid_next       = tid_reg;
        rem_next       = rem_reg;
        fix_next       = fix_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        n_next         = n_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        have_prev_next = have_prev_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        ram_we         = '0;
        wr_addr        = cur_reg;
        wr_tid         = tid_reg;
        wr_delta       = rem_reg;
        wr_next        = '0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        fm_ctrl        = '0;
        rel_idx        = cur_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            dsq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.opcode;
                    tid_next       = req.task_id;
                    rem_next       = req.delay;
                    have_prev_next = 1'b0;
                    k_next         = '0;
                    res_next       = '{status: dsq_pkg::STAT_OK, out_task: 8'd0,
                                       out_delta: 16'd0};
                    link_next      = is_empty ? dsq_pkg::LK_NONE : dsq_pkg::LK_TAIL;
                    unique case (req.opcode)
                        dsq_pkg::OP_APPEND,
                        dsq_pkg::OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_next.status = dsq_pkg::STAT_FULL;
                            end
                        end
                        dsq_pkg::OP_POP:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = dsq_pkg::STAT_EMPTY;
                            end
                        end
                        dsq_pkg::OP_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                res_next.status = dsq_pkg::STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            res_next.status = dsq_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            dsq_pkg::S_POP_RD,
            dsq_pkg::S_WALK_RD:
            begin
                rd_en    = 1'b1;
                rd_addr  = head_reg;
                cur_next = head_reg;
            end
            dsq_pkg::S_POP_CHK:
            begin
                res_next   = '{status: dsq_pkg::STAT_OK, out_task: rd_tid,
                               out_delta: rd_delta};
                fm_ctrl.give = 1'b1;
                rel_idx    = cur_reg;
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = rd_next;
                end
            end
            dsq_pkg::S_WALK_CHK:
            begin
                if (op_reg == dsq_pkg::OP_INSERT)
                begin
                    if (delta_lt)
                    begin
                        // Skip this entry: consume its delta and step on.
                        rem_next       = rem_reg - rd_delta;
                        prev_next      = cur_reg;
                        have_prev_next = 1'b1;
                        cur_next       = rd_next;
                        k_next         = k_inc;
                        if (walk_last)
                        begin
                            link_next = dsq_pkg::LK_TAIL;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = rd_next;
                        end
                    end
                    else
                    begin
                        // Insert ahead of this entry, which keeps what is left.
                        fix_next  = rd_delta - rem_reg;
                        link_next = have_prev_reg ? dsq_pkg::LK_PREV : dsq_pkg::LK_HEAD;
                    end
                end
                else if (id_match)
                begin
                    // Unlink; the delta of the removed entry is dropped.
                    if (have_prev_reg)
                    begin
                        ram_we.next_en = 1'b1;
                        wr_addr        = prev_reg;
                        wr_next        = rd_next;
                    end
                    else
                    begin
                        head_next = rd_next;
                    end
                    if (tail_reg == cur_reg)
                    begin
                        tail_next = have_prev_reg ? prev_reg : '0;
                    end
                    fm_ctrl.give = 1'b1;
                    rel_idx    = cur_reg;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
                else
                begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next       = rd_next;
                    k_next         = k_inc;
                    if (walk_last)
                    begin
                        res_next.status = dsq_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_next;
                    end
                end
            end
            dsq_pkg::S_FIX:
            begin
                ram_we.delta_en = 1'b1;
                wr_addr         = cur_reg;
                wr_delta        = fix_reg;
            end
            dsq_pkg::S_NEW:
            begin
                ram_we       = '{tid_en: 1'b1, delta_en: 1'b1, next_en: 1'b1};
                wr_addr      = alloc_idx;
                wr_tid       = tid_reg;
                wr_delta     = rem_reg;
                wr_next      = (link_reg == dsq_pkg::LK_HEAD ||
                                link_reg == dsq_pkg::LK_PREV) ? cur_reg : '0;
                fm_ctrl.take = 1'b1;
                n_next       = alloc_idx;
                count_next   = count_reg + CW'(1);
                unique case (link_reg)
                    dsq_pkg::LK_NONE:
                    begin
                        head_next = alloc_idx;
                        tail_next = alloc_idx;
                    end
                    dsq_pkg::LK_HEAD:
                    begin
                        head_next = alloc_idx;
                    end
                    dsq_pkg::LK_TAIL,
                    dsq_pkg::LK_PREV:
                    begin
                        head_next = head_reg;
                    end
                    default:
                    begin
                        head_next = head_reg;
                    end
                endcase
            end
            dsq_pkg::S_LINK:
            begin
                ram_we.next_en = 1'b1;
                wr_next        = n_reg;
                if (link_reg == dsq_pkg::LK_TAIL)
                begin
                    wr_addr   = tail_reg;
                    tail_next = n_reg;
                end
                else
                begin
                    wr_addr = prev_reg;
                end
            end
            dsq_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dsq_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    // Working registers of the current request; they need no reset.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        link_reg      <= link_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
        tid_reg       <= tid_next;
        rem_reg       <= rem_next;
        fix_reg       <= fix_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        n_reg         <= n_next;
        have_prev_reg <= have_prev_next;
        k_reg         <= k_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH))
    `ASSERT_IMPL(a_empty_ptrs, clk, rst_n, count_reg == '0,
                 head_reg == '0 && tail_reg == '0)
    `ASSERT_IMPL(a_pool_balance, clk, rst_n, state_reg == dsq_pkg::S_IDLE,
                 $countones(free_mask) + int'(count_reg) == DEPTH)
    `ASSERT_IMPL(a_rsp_from_done, clk, rst_n, $rose(rsp_valid_reg),
                 $past(state_reg == dsq_pkg::S_DONE))

endmodule
